>>> rtl/core/mhf_pkg.sv
package mhf_pkg;

    // field widths fixed by the interface
    localparam int RAW_W  = 13;
    localparam int FILT_W = 14;
    localparam int HEAD_W = 15;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_X_OFFSET = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_OFFSET = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_Z_OFFSET = 2'd2;

    // offset reset values
    localparam logic [RAW_W-1:0] X_OFFSET_RST = 13'h1F5E;  // -162
    localparam logic [RAW_W-1:0] Y_OFFSET_RST = 13'h005E;  //  94
    localparam logic [RAW_W-1:0] Z_OFFSET_RST = 13'h1FE6;  // -26

    // cordic formats: vector scaled by 2^16, angle in degrees * 2^16
    localparam int ANG_FRAC  = 16;
    localparam int TABLE_LEN = 24;
    localparam int ITER_W    = 5;
    localparam int XY_W      = 33;
    localparam int ANG_W     = 27;
    localparam int ATAN_W    = 22;

    localparam int CORDIC_ITERATIONS_DEF = 16;
    localparam int HEADING_FRAC_BITS_DEF = 6;

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [FILT_W-1:0] x;
        logic [FILT_W-1:0] y;
        logic [FILT_W-1:0] z;
    } t_mhf_sample;

    typedef struct packed {
        logic full;
        logic empty;
    } t_mhf_qstat;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_ITER,
        BK_WRAP,
        BK_ROUND,
        BK_DONE
    } t_back_state;

    // atan(2^-i) in degrees * 2^16, rounded to nearest
    function automatic logic [ATAN_W-1:0] atan_deg(input logic [ITER_W-1:0] idx);
        logic [ATAN_W-1:0] v;
        begin
            unique case (idx)
                5'd0:    v = 22'd2949120;
                5'd1:    v = 22'd1740967;
                5'd2:    v = 22'd919879;
                5'd3:    v = 22'd466945;
                5'd4:    v = 22'd234379;
                5'd5:    v = 22'd117304;
                5'd6:    v = 22'd58666;
                5'd7:    v = 22'd29335;
                5'd8:    v = 22'd14668;
                5'd9:    v = 22'd7334;
                5'd10:   v = 22'd3667;
                5'd11:   v = 22'd1833;
                5'd12:   v = 22'd917;
                5'd13:   v = 22'd458;
                5'd14:   v = 22'd229;
                5'd15:   v = 22'd115;
                5'd16:   v = 22'd57;
                5'd17:   v = 22'd29;
                5'd18:   v = 22'd14;
                5'd19:   v = 22'd7;
                5'd20:   v = 22'd4;
                5'd21:   v = 22'd2;
                5'd22:   v = 22'd1;
                default: v = 22'd0;
            endcase
            return v;
        end
    endfunction

endpackage

>>> rtl/core/magnetometer_heading_filter_top.sv
// Magnetometer heading filter. Each item carries one raw three-axis sample;
// the front end subtracts the hard-iron offsets, updates the three smoothing
// averages and queues the filtered vector in the cycle the item is taken, so
// a new item is taken whenever the two-entry queue has room. The back end
// turns each queued vector into a heading with an iterative CORDIC, one
// rotation per cycle, and takes the next vector from the queue only once
// it has handed the last result on. Results are held in an output register,
// so the back end carries on while a result waits. The heading is in degrees
// times 2^HEADING_FRAC_BITS, in [0, 360), and reads 0 for a zero vector.
// The offset registers are written through the configuration port, which is
// always ready; write them only while no item is in flight.
module magnetometer_heading_filter_top #(
    parameter int CORDIC_ITERATIONS = mhf_pkg::CORDIC_ITERATIONS_DEF,
    parameter int HEADING_FRAC_BITS = mhf_pkg::HEADING_FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [mhf_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [mhf_pkg::RAW_W-1:0]         i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [mhf_pkg::RAW_W-1:0]         i_x_raw,
    input  logic [mhf_pkg::RAW_W-1:0]         i_y_raw,
    input  logic [mhf_pkg::RAW_W-1:0]         i_z_raw,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [mhf_pkg::FILT_W-1:0]        o_filtered_x,
    output logic [mhf_pkg::FILT_W-1:0]        o_filtered_y,
    output logic [mhf_pkg::FILT_W-1:0]        o_filtered_z,
    output logic [mhf_pkg::HEAD_W-1:0]        o_heading_deg
);

    logic                 w_push, w_pop;
    mhf_pkg::t_mhf_sample w_wdata, w_rdata;
    mhf_pkg::t_mhf_qstat  w_qstat;

    assign o_cfg_ready = 1'b1;

    mhf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .i_x_raw     (i_x_raw),
        .i_y_raw     (i_y_raw),
        .i_z_raw     (i_z_raw),
        .i_qstat     (w_qstat),
        .o_in_stall  (o_in_stall),
        .o_push      (w_push),
        .o_push_data (w_wdata)
    );

    mhf_queue #(
        .DEPTH (mhf_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_wdata (w_wdata),
        .i_pop   (w_pop),
        .o_rdata (w_rdata),
        .o_stat  (w_qstat)
    );

    mhf_back #(
        .CORDIC_ITERATIONS (CORDIC_ITERATIONS),
        .HEADING_FRAC_BITS (HEADING_FRAC_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_qdata       (w_rdata),
        .i_qstat       (w_qstat),
        .o_pop         (w_pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_filtered_x  (o_filtered_x),
        .o_filtered_y  (o_filtered_y),
        .o_filtered_z  (o_filtered_z),
        .o_heading_deg (o_heading_deg)
    );

endmodule

>>> rtl/core/mhf_front.sv
module mhf_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    input  logic [mhf_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [mhf_pkg::RAW_W-1:0]         i_cfg_data,
    input  logic                              i_in_valid,
    input  logic [mhf_pkg::RAW_W-1:0]         i_x_raw,
    input  logic [mhf_pkg::RAW_W-1:0]         i_y_raw,
    input  logic [mhf_pkg::RAW_W-1:0]         i_z_raw,
    input  mhf_pkg::t_mhf_qstat               i_qstat,
    output logic                              o_in_stall,
    output logic                              o_push,
    output mhf_pkg::t_mhf_sample              o_push_data
);

    logic [mhf_pkg::RAW_W-1:0]  r_x_off, r_y_off, r_z_off;
    logic [mhf_pkg::FILT_W-1:0] r_avg_x, r_avg_y, r_avg_z;
    logic [mhf_pkg::FILT_W-1:0] w_cx, w_cy, w_cz;
    logic                       w_seed;
    logic                       w_accept;

    function automatic logic [mhf_pkg::FILT_W-1:0] correct(
        input logic [mhf_pkg::RAW_W-1:0] raw,
        input logic [mhf_pkg::RAW_W-1:0] off
    );
        begin
            return {raw[mhf_pkg::RAW_W-1], raw} - {off[mhf_pkg::RAW_W-1], off};
        end
    endfunction

    // floor((3*s + 5*old) / 8)
    function automatic logic [mhf_pkg::FILT_W-1:0] smooth(
        input logic [mhf_pkg::FILT_W-1:0] s,
        input logic [mhf_pkg::FILT_W-1:0] old
    );
        logic signed [17:0] se;
        logic signed [17:0] oe;
        logic signed [17:0] sum;
        begin
            se  = {{4{s[mhf_pkg::FILT_W-1]}}, s};
            oe  = {{4{old[mhf_pkg::FILT_W-1]}}, old};
            sum = (se <<< 1) + se + (oe <<< 2) + oe;
            return sum[mhf_pkg::FILT_W+2:3];
        end
    endfunction

    assign w_cx     = correct(i_x_raw, r_x_off);
    assign w_cy     = correct(i_y_raw, r_y_off);
    assign w_cz     = correct(i_z_raw, r_z_off);
    assign w_seed   = (r_avg_x == '0) && (r_avg_y == '0);
    assign w_accept = i_in_valid && !o_in_stall;

    assign o_in_stall  = i_qstat.full;
    assign o_push      = w_accept;
    assign o_push_data.x = smooth(w_cx, w_seed ? w_cx : r_avg_x);
    assign o_push_data.y = smooth(w_cy, w_seed ? w_cy : r_avg_y);
    assign o_push_data.z = smooth(w_cz, w_seed ? w_cz : r_avg_z);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_off <= mhf_pkg::X_OFFSET_RST;
            r_y_off <= mhf_pkg::Y_OFFSET_RST;
            r_z_off <= mhf_pkg::Z_OFFSET_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                mhf_pkg::CFG_X_OFFSET: r_x_off <= i_cfg_data;
                mhf_pkg::CFG_Y_OFFSET: r_y_off <= i_cfg_data;
                mhf_pkg::CFG_Z_OFFSET: r_z_off <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_avg_x <= '0;
            r_avg_y <= '0;
            r_avg_z <= '0;
        end else if (w_accept) begin
            r_avg_x <= o_push_data.x;
            r_avg_y <= o_push_data.y;
            r_avg_z <= o_push_data.z;
        end
    end

endmodule

>>> rtl/core/mhf_queue.sv
module mhf_queue #(
    parameter int DEPTH = mhf_pkg::QUEUE_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  mhf_pkg::t_mhf_sample  i_wdata,
    input  logic                  i_pop,
    output mhf_pkg::t_mhf_sample  o_rdata,
    output mhf_pkg::t_mhf_qstat   o_stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    mhf_pkg::t_mhf_sample r_mem [DEPTH];
    logic [PTR_W-1:0]     r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]     r_count;

    assign o_rdata      = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == CNT_FULL);
    assign o_stat.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_stat.full || i_pop)
        else $error("item pushed into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_stat.empty)
        else $error("item popped from empty queue");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_FULL)
        else $error("queue count beyond depth");

endmodule

>>> rtl/core/mhf_back.sv
module mhf_back #(
    parameter int CORDIC_ITERATIONS = mhf_pkg::CORDIC_ITERATIONS_DEF,
    parameter int HEADING_FRAC_BITS = mhf_pkg::HEADING_FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  mhf_pkg::t_mhf_sample          i_qdata,
    input  mhf_pkg::t_mhf_qstat           i_qstat,
    output logic                          o_pop,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [mhf_pkg::FILT_W-1:0]    o_filtered_x,
    output logic [mhf_pkg::FILT_W-1:0]    o_filtered_y,
    output logic [mhf_pkg::FILT_W-1:0]    o_filtered_z,
    output logic [mhf_pkg::HEAD_W-1:0]    o_heading_deg
);

    localparam int XY_W   = mhf_pkg::XY_W;
    localparam int ANG_W  = mhf_pkg::ANG_W;
    localparam int ITER_W = mhf_pkg::ITER_W;
    localparam int SHIFT  = mhf_pkg::ANG_FRAC - HEADING_FRAC_BITS;
    localparam int PAD_W  = XY_W - mhf_pkg::FILT_W - mhf_pkg::ANG_FRAC;

    localparam logic [ITER_W-1:0] ITER_LAST  = ITER_W'(CORDIC_ITERATIONS - 1);
    localparam logic [ANG_W-1:0]  ANG_FULL   = ANG_W'(360 * (1 << mhf_pkg::ANG_FRAC));
    localparam logic [ANG_W-1:0]  ANG_HALF_T = ANG_W'(180 * (1 << mhf_pkg::ANG_FRAC));
    localparam logic [ANG_W-1:0]  RND_HALF   = ANG_W'(1 << (SHIFT - 1));
    localparam logic [ANG_W-1:0]  PERIOD     = ANG_W'(360 * (1 << HEADING_FRAC_BITS));

    mhf_pkg::t_back_state r_state, n_state;

    logic [ITER_W-1:0]        r_iter;
    logic signed [XY_W-1:0]   r_x, r_y;
    logic signed [ANG_W-1:0]  r_z;
    logic [ANG_W-1:0]         r_head;
    logic                     r_zero;
    mhf_pkg::t_mhf_sample     r_smp;
    logic                     r_out_valid;
    mhf_pkg::t_mhf_sample     r_out;
    logic [mhf_pkg::HEAD_W-1:0] r_out_head;

    logic                     w_load_out;
    logic signed [XY_W-1:0]   w_x0, w_y0, w_dx, w_dy;
    logic signed [ANG_W-1:0]  w_atan;
    logic [ANG_W-1:0]         w_rnd;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mhf_pkg::BK_IDLE:  if (!i_qstat.empty) n_state = mhf_pkg::BK_ITER;
            mhf_pkg::BK_ITER:  if (r_iter == ITER_LAST) n_state = mhf_pkg::BK_WRAP;
            mhf_pkg::BK_WRAP:  n_state = mhf_pkg::BK_ROUND;
            mhf_pkg::BK_ROUND: n_state = mhf_pkg::BK_DONE;
            mhf_pkg::BK_DONE:  if (!r_out_valid || !i_out_stall) n_state = mhf_pkg::BK_IDLE;
            default:           n_state = mhf_pkg::BK_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_pop      = 1'b0;
        w_load_out = 1'b0;
        unique case (r_state)
            mhf_pkg::BK_IDLE: o_pop      = !i_qstat.empty;
            mhf_pkg::BK_DONE: w_load_out = !r_out_valid || !i_out_stall;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mhf_pkg::BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // vector scaled by 2^16, turned by 180 degrees in the left half plane
    assign w_x0 = {{PAD_W{i_qdata.x[mhf_pkg::FILT_W-1]}}, i_qdata.x,
                   {mhf_pkg::ANG_FRAC{1'b0}}};
    assign w_y0 = {{PAD_W{i_qdata.y[mhf_pkg::FILT_W-1]}}, i_qdata.y,
                   {mhf_pkg::ANG_FRAC{1'b0}}};

    assign w_dx   = r_y >>> r_iter;
    assign w_dy   = r_x >>> r_iter;
    assign w_atan = {{(ANG_W - mhf_pkg::ATAN_W){1'b0}}, mhf_pkg::atan_deg(r_iter)};
    assign w_rnd  = (r_z + RND_HALF) >> SHIFT;

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            mhf_pkg::BK_IDLE: begin
                r_smp  <= i_qdata;
                r_zero <= (i_qdata.x == '0) && (i_qdata.y == '0);
                r_iter <= '0;
                if (i_qdata.x[mhf_pkg::FILT_W-1]) begin
                    r_x <= -w_x0;
                    r_y <= -w_y0;
                    r_z <= ANG_HALF_T;
                end else begin
                    r_x <= w_x0;
                    r_y <= w_y0;
                    r_z <= '0;
                end
            end
            mhf_pkg::BK_ITER: begin
                r_iter <= r_iter + 1'b1;
                if (!r_y[XY_W-1]) begin
                    r_x <= r_x + w_dx;
                    r_y <= r_y - w_dy;
                    r_z <= r_z + w_atan;
                end else begin
                    r_x <= r_x - w_dx;
                    r_y <= r_y + w_dy;
                    r_z <= r_z - w_atan;
                end
            end
            mhf_pkg::BK_WRAP: begin
                // angle never reaches a full turn, only negatives need folding
                if (r_z[ANG_W-1]) begin
                    r_z <= r_z + ANG_FULL;
                end
            end
            mhf_pkg::BK_ROUND: begin
                if (r_zero) begin
                    r_head <= '0;
                end else if (w_rnd >= PERIOD) begin
                    r_head <= w_rnd - PERIOD;
                end else begin
                    r_head <= w_rnd;
                end
            end
            default: begin
            end
        endcase
    end

    // output register, frees the back end while a result waits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out      <= r_smp;
            r_out_head <= r_head[mhf_pkg::HEAD_W-1:0];
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_filtered_x  = r_out.x;
    assign o_filtered_y  = r_out.y;
    assign o_filtered_z  = r_out.z;
    assign o_heading_deg = r_out_head;

    a_iter_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == mhf_pkg::BK_ITER |-> r_iter <= ITER_LAST)
        else $error("cordic step count past the last iteration");

    a_head_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == mhf_pkg::BK_DONE |-> r_head < PERIOD)
        else $error("heading not wrapped into one turn");

    a_zero_heading: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load_out && r_zero) |=> o_heading_deg == '0)
        else $error("zero vector gave a nonzero heading");

endmodule
